// File: rtl/core/iirdf_pkg.sv
// iirdf_pkg: shared types and constants for the multichannel direct form I IIR filter
// holds the item, history and coefficient layouts and the register index codes
// no dependencies
package iirdf_pkg;

	// fixed filter geometry
	localparam int TAPS        = 4;
	localparam int HIST_SLOTS  = TAPS - 1;
	localparam int SAMPLE_W    = 16;
	localparam int COEF_W      = 16;
	localparam int CHAN_W      = 3;
	localparam int FRAC_BITS   = 14;
	localparam int PROD_W      = SAMPLE_W + COEF_W;
	localparam int ACC_W       = PROD_W + 4;
	localparam int QUEUE_DEPTH = 4;
	localparam int CFG_IDX_W   = 3;
	localparam int TUSER_W     = CHAN_W + 1;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_B_TAP0 = 3'd0,
		REG_B_TAP1 = 3'd1,
		REG_B_TAP2 = 3'd2,
		REG_B_TAP3 = 3'd3,
		REG_A_FB1  = 3'd4,
		REG_A_FB2  = 3'd5,
		REG_A_FB3  = 3'd6
	} cfg_reg_t;

	typedef logic [SAMPLE_W-1:0] sample_t;
	typedef logic [COEF_W-1:0]   coef_t;

	// b[k] weighs x[n-k], a[k] weighs y[n-k]
	typedef struct packed {
		coef_t [TAPS-1:0] b;
		coef_t [TAPS-1:1] a;
	} coef_set_t;

	// one input item
	typedef struct packed {
		logic [CHAN_W-1:0] chan;
		logic              seq_start;
		sample_t           sample;
	} item_t;

	localparam int ITEM_W = $bits(item_t);

	// per channel history, x[k] holds x[n-1-k], y[k] holds y[n-1-k]
	typedef struct packed {
		sample_t [HIST_SLOTS-1:0] x;
		sample_t [HIST_SLOTS-1:0] y;
	} hist_t;

	// b_tap0 resets to 1.0 in Q2.14, all others to zero
	localparam coef_set_t COEF_RESET = '{
		b: {coef_t'(0), coef_t'(0), coef_t'(0), coef_t'(16384)},
		a: '0
	};

endpackage

// File: rtl/core/iir_filter_direct_form.sv
// iir_filter_direct_form: top level of the multichannel direct form I IIR filter
// depends on iirdf_pkg, iirdf_coef, iirdf_front, iirdf_fifo, iirdf_back
//
//   channel  direction  handshake              payload
//   s_       in         s_tvalid / s_tready    s_tdata sample_in, s_tuser chan, seq_start
//   m_       out        m_tvalid / m_tready    m_tdata sample_out, m_tuser chan_out, overflow
//   cfg_     in         cfg_valid / cfg_ready  cfg_index register, cfg_data value
//
// one item per cycle while the output is not stalled and no item of the same channel sits
// in the three pipeline stages; an item whose channel is in flight waits for its history
// write-back. an item passes from the queue through stages 1 to 3 into the output register.
// reset clears the history valid bits at once, so no clearing pass is needed.
// a stalled output freezes the pipeline; the 4-entry queue keeps taking items until it is full.
module iir_filter_direct_form #(
	parameter int NUM_CHANNELS = 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [iirdf_pkg::SAMPLE_W-1:0]     s_tdata,   // [15:0] sample_in
	input  logic [iirdf_pkg::TUSER_W-1:0]      s_tuser,   // [2:0] chan, [3] seq_start
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [iirdf_pkg::SAMPLE_W-1:0]     m_tdata,   // [15:0] sample_out
	output logic [iirdf_pkg::TUSER_W-1:0]      m_tuser,   // [2:0] chan_out, [3] overflow
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [iirdf_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [iirdf_pkg::COEF_W-1:0]       cfg_data
);
	import iirdf_pkg::*;

	localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int QW   = CH_W + ITEM_W;

	coef_set_t       coef;
	logic            q_push;
	logic            q_full;
	logic [QW-1:0]   q_wdata;
	logic            q_pop;
	logic            q_valid;
	logic [QW-1:0]   q_rdata;

	// coefficient registers
	iirdf_coef u_coef (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.coef      (coef)
	);

	// input side
	iirdf_front #(
		.NUM_CHANNELS (NUM_CHANNELS),
		.CH_W         (CH_W)
	) u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_wdata  (q_wdata)
	);

	// queue between input side and pipeline
	iirdf_fifo #(
		.W     (QW),
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.pop    (q_pop),
		.valid  (q_valid),
		.rdata  (q_rdata)
	);

	// filter pipeline
	iirdf_back #(
		.NUM_CHANNELS (NUM_CHANNELS),
		.CH_W         (CH_W)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.coef     (coef),
		.q_valid  (q_valid),
		.q_rdata  (q_rdata),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

// File: rtl/core/iirdf_coef.sv
// iirdf_coef: coefficient register file written through the configuration channel
// depends on iirdf_pkg
module iirdf_coef (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [iirdf_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [iirdf_pkg::COEF_W-1:0]       cfg_data,
	output iirdf_pkg::coef_set_t               coef
);
	import iirdf_pkg::*;

	coef_set_t coef_q;

	// writes are always taken, unknown indexes are dropped
	assign cfg_ready = 1'b1;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q <= COEF_RESET;
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				REG_B_TAP0: coef_q.b[0] <= cfg_data;
				REG_B_TAP1: coef_q.b[1] <= cfg_data;
				REG_B_TAP2: coef_q.b[2] <= cfg_data;
				REG_B_TAP3: coef_q.b[3] <= cfg_data;
				REG_A_FB1:  coef_q.a[1] <= cfg_data;
				REG_A_FB2:  coef_q.a[2] <= cfg_data;
				REG_A_FB3:  coef_q.a[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	assign coef = coef_q;

endmodule

// File: rtl/core/iirdf_front.sv
// iirdf_front: input side, takes items and folds the channel onto a history slot
// depends on iirdf_pkg, feeds iirdf_fifo
module iirdf_front #(
	parameter int NUM_CHANNELS = 8,
	parameter int CH_W         = 3
) (
	input  logic                                       s_tvalid,
	output logic                                       s_tready,
	input  logic [iirdf_pkg::SAMPLE_W-1:0]             s_tdata,
	input  logic [iirdf_pkg::TUSER_W-1:0]              s_tuser,
	input  logic                                       q_full,
	output logic                                       q_push,
	output logic [CH_W+iirdf_pkg::ITEM_W-1:0]          q_wdata
);
	import iirdf_pkg::*;

	localparam int FOLD_W = CHAN_W + 6;

	item_t             item;
	logic [FOLD_W-1:0] fold;

	// unpack tuser: chan low, seq_start high
	assign item.chan      = s_tuser[CHAN_W-1:0];
	assign item.seq_start = s_tuser[CHAN_W];
	assign item.sample    = s_tdata;

	// channel modulo channel count by repeated compare and subtract
	always_comb begin
		fold = FOLD_W'(item.chan);
		for (int i = 0; i < (1 << CHAN_W); i++) begin
			if (fold >= FOLD_W'(NUM_CHANNELS)) begin
				fold = fold - FOLD_W'(NUM_CHANNELS);
			end
		end
	end

	// push while the queue has room
	assign s_tready = !q_full;
	assign q_push   = s_tvalid && !q_full;
	assign q_wdata  = {fold[CH_W-1:0], item};

endmodule

// File: rtl/core/iirdf_fifo.sv
// iirdf_fifo: short queue between the input side and the filter pipeline
// depends on nothing outside itself
module iirdf_fifo #(
	parameter int W     = 24,
	parameter int DEPTH = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	output logic         full,
	input  logic         pop,
	output logic         valid,
	output logic [W-1:0] rdata
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [W-1:0]     mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full  = (count_q == CNT_W'(DEPTH));
	assign valid = (count_q != '0);
	assign rdata = mem_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

// File: rtl/core/iirdf_back.sv
// iirdf_back: filter pipeline with per channel history memory and output register
// depends on iirdf_pkg, drains iirdf_fifo
module iirdf_back #(
	parameter int NUM_CHANNELS = 8,
	parameter int CH_W         = 3
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  iirdf_pkg::coef_set_t                   coef,
	input  logic                                   q_valid,
	input  logic [CH_W+iirdf_pkg::ITEM_W-1:0]      q_rdata,
	output logic                                   q_pop,
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	output logic [iirdf_pkg::SAMPLE_W-1:0]         m_tdata,
	output logic [iirdf_pkg::TUSER_W-1:0]          m_tuser
);
	import iirdf_pkg::*;

	localparam logic signed [ACC_W-1:0] ROUND   = ACC_W'(1 << (FRAC_BITS - 1));
	localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(32767);
	localparam logic signed [ACC_W-1:0] SAT_MIN = -ACC_W'(32768);

	// queue head
	logic [CH_W-1:0] head_idx;
	item_t           head;
	logic            hazard;
	logic            adv;

	// history storage
	hist_t             hist_mem [NUM_CHANNELS];
	logic [NUM_CHANNELS-1:0] hist_vld_q;

	// stage 1: history read
	logic            vld_s1;
	logic [CH_W-1:0] idx_s1;
	item_t           item_s1;
	hist_t           rd_s1;
	logic            rd_vld_s1;

	// stage 2: products
	logic                     vld_s2;
	logic [CH_W-1:0]          idx_s2;
	logic [CHAN_W-1:0]        chan_s2;
	hist_t                    hist_s2;
	logic signed [PROD_W-1:0] prod_b_s2 [TAPS];
	logic signed [PROD_W-1:0] prod_a_s2 [1:TAPS-1];

	// stage 3: partial sums
	logic                    vld_s3;
	logic [CH_W-1:0]         idx_s3;
	logic [CHAN_W-1:0]       chan_s3;
	hist_t                   hist_s3;
	logic signed [ACC_W-1:0] ff_s3;
	logic signed [ACC_W-1:0] fb_s3;

	// output register
	logic                m_tvalid_q;
	logic [SAMPLE_W-1:0] m_tdata_q;
	logic [TUSER_W-1:0]  m_tuser_q;

	// stage 1 logic
	hist_t                      h;
	hist_t                      nh;
	logic signed [SAMPLE_W-1:0] xs [TAPS];
	logic signed [SAMPLE_W-1:0] ys [1:TAPS-1];
	logic signed [COEF_W-1:0]   bs [TAPS];
	logic signed [COEF_W-1:0]   as_c [1:TAPS-1];
	logic signed [PROD_W-1:0]   pb [TAPS];
	logic signed [PROD_W-1:0]   pa [1:TAPS-1];

	// stage 2 and 3 logic
	logic signed [ACC_W-1:0]    ff;
	logic signed [ACC_W-1:0]    fb;
	logic signed [ACC_W-1:0]    acc;
	logic signed [ACC_W-1:0]    shifted;
	logic signed [SAMPLE_W-1:0] ysat;
	logic                       ovf;
	hist_t                      wr_hist;

	assign head_idx = q_rdata[CH_W+ITEM_W-1:ITEM_W];
	assign head     = item_t'(q_rdata[ITEM_W-1:0]);

	// pipeline moves whenever the output register can take a result
	assign adv = !m_tvalid_q || m_tready;

	// an item waits while its channel is still in flight
	assign hazard = (vld_s1 && (idx_s1 == head_idx)) ||
			(vld_s2 && (idx_s2 == head_idx)) ||
			(vld_s3 && (idx_s3 == head_idx));

	assign q_pop = adv && q_valid && !hazard;

	// history memory, read at issue and written back from stage 3
	always_ff @(posedge clk) begin
		if (adv) begin
			rd_s1 <= hist_mem[head_idx];
			if (vld_s3) begin
				hist_mem[idx_s3] <= wr_hist;
			end
		end
	end

	// stage valids and history valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_vld_q <= '0;
			rd_vld_s1  <= 1'b0;
			vld_s1     <= 1'b0;
			vld_s2     <= 1'b0;
			vld_s3     <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else if (adv) begin
			rd_vld_s1  <= hist_vld_q[head_idx];
			vld_s1     <= q_valid && !hazard;
			vld_s2     <= vld_s1;
			vld_s3     <= vld_s2;
			m_tvalid_q <= vld_s3;
			if (vld_s3) begin
				hist_vld_q[idx_s3] <= 1'b1;
			end
		end
	end

	// stage 1: clear history on start or first use, form products
	always_comb begin
		h = rd_s1;
		if (item_s1.seq_start || !rd_vld_s1) begin
			h = '0;
		end
		xs[0] = item_s1.sample;
		bs[0] = coef.b[0];
		for (int k = 1; k < TAPS; k++) begin
			xs[k]   = h.x[k-1];
			ys[k]   = h.y[k-1];
			bs[k]   = coef.b[k];
			as_c[k] = coef.a[k];
		end
		for (int k = 0; k < TAPS; k++) begin
			pb[k] = bs[k] * xs[k];
		end
		for (int k = 1; k < TAPS; k++) begin
			pa[k] = as_c[k] * ys[k];
		end
		// shifted history, newest output slot filled in stage 3
		nh      = '0;
		nh.x[0] = item_s1.sample;
		for (int k = 1; k < HIST_SLOTS; k++) begin
			nh.x[k] = h.x[k-1];
			nh.y[k] = h.y[k-1];
		end
	end

	// stage 2: feedforward and feedback sums, rounding constant folded in
	always_comb begin
		ff = ROUND;
		fb = '0;
		for (int k = 0; k < TAPS; k++) begin
			ff = ff + ACC_W'(prod_b_s2[k]);
		end
		for (int k = 1; k < TAPS; k++) begin
			fb = fb + ACC_W'(prod_a_s2[k]);
		end
	end

	// stage 3: combine, floor shift, saturate
	always_comb begin
		acc     = ff_s3 - fb_s3;
		shifted = acc >>> FRAC_BITS;
		ovf     = 1'b0;
		ysat    = shifted[SAMPLE_W-1:0];
		if (shifted > SAT_MAX) begin
			ysat = SAT_MAX[SAMPLE_W-1:0];
			ovf  = 1'b1;
		end else if (shifted < SAT_MIN) begin
			ysat = SAT_MIN[SAMPLE_W-1:0];
			ovf  = 1'b1;
		end
		wr_hist      = hist_s3;
		wr_hist.y[0] = ysat;
	end

	// pipeline payload
	always_ff @(posedge clk) begin
		if (adv) begin
			idx_s1    <= head_idx;
			item_s1   <= head;
			idx_s2    <= idx_s1;
			chan_s2   <= item_s1.chan;
			hist_s2   <= nh;
			prod_b_s2 <= pb;
			prod_a_s2 <= pa;
			idx_s3    <= idx_s2;
			chan_s3   <= chan_s2;
			hist_s3   <= hist_s2;
			ff_s3     <= ff;
			fb_s3     <= fb;
			if (vld_s3) begin
				m_tdata_q <= ysat;
				m_tuser_q <= {ovf, chan_s3};
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

// File: rtl/core/iirdf_checker.sv
// iirdf_checker: port level checks for the IIR filter, bound to the top level
// depends on iirdf_pkg and iir_filter_direct_form
module iirdf_checker #(
	parameter int MAX_INFLIGHT = 8
) (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               s_tvalid,
	input logic                               s_tready,
	input logic                               m_tvalid,
	input logic                               m_tready,
	input logic [iirdf_pkg::SAMPLE_W-1:0]     m_tdata,
	input logic [iirdf_pkg::TUSER_W-1:0]      m_tuser
);
	import iirdf_pkg::*;

	localparam int CNT_W = $clog2(MAX_INFLIGHT + 2);

	logic             in_acc;
	logic             out_acc;
	logic [CNT_W-1:0] pending_q;

	assign in_acc  = s_tvalid && s_tready;
	assign out_acc = m_tvalid && m_tready;

	// items taken but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			case ({in_acc, out_acc})
				2'b10:   pending_q <= pending_q + 1'b1;
				2'b01:   pending_q <= pending_q - 1'b1;
				default: pending_q <= pending_q;
			endcase
		end
	end

	// a result waits until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("output item dropped while stalled");

	// overflow only with a saturated sample
	a_ovf_sat: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[CHAN_W] |-> (m_tdata == 16'h7fff || m_tdata == 16'h8000))
		else $error("overflow flag without saturated sample");

	// no result without an item behind it
	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc |-> pending_q != '0)
		else $error("output item without matching input item");

	// queue and pipeline bound the items in flight
	a_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= CNT_W'(MAX_INFLIGHT))
		else $error("too many items in flight");

endmodule

bind iir_filter_direct_form iirdf_checker #(
	.MAX_INFLIGHT (8)
) u_iirdf_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

// File: tb/iir_filter_direct_form_tb.sv
// iir_filter_direct_form_tb: self-checking bench for the multichannel direct form I IIR filter
// drives sample items and coefficient writes, predicts each filtered item and checks it in order
// depends on iirdf_pkg and iir_filter_direct_form
module iir_filter_direct_form_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import iirdf_pkg::*;

	localparam int          CLK_PERIOD     = 10;
	localparam int          NUM_CH         = 8;
	localparam int          STALL_LIMIT    = 4000;
	localparam int          TAIL_CYCLES    = 20;
	localparam int          PHASES         = 10;
	localparam int          PHASE_ITEMS    = 185;
	localparam longint      ROUND_HALF     = 64'sd1 <<< (FRAC_BITS - 1);
	localparam logic [15:0] UNITY_Q14      = 16'sd16384;
	localparam logic [15:0] POS_FULL       = 16'h7fff;
	localparam logic [15:0] NEG_FULL       = 16'h8000;
	localparam logic [2:0]  CFG_IDX_UNUSED = 3'd7;

	// coefficient set kinds picked per phase
	localparam int SET_UNITY   = 0;
	localparam int SET_EXTREME = 1;
	localparam int SET_RANDOM  = 2;
	localparam int SET_MILD    = 3;
	localparam int SET_FIR     = 4;

	// one filtered item as seen on the output
	typedef struct packed {
		logic [CHAN_W-1:0]   chan;
		logic [SAMPLE_W-1:0] value;
		logic                ovf;
	} filter_out_t;

	// one row of the directed table: a register write or a sample item
	typedef struct packed {
		logic                is_write;
		logic [2:0]          idx;
		logic [COEF_W-1:0]   coef;
		logic [CHAN_W-1:0]   chan;
		logic                start;
		logic [SAMPLE_W-1:0] x;
		logic                known;
		logic [SAMPLE_W-1:0] want;
		logic                want_ovf;
	} step_t;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 s_tvalid  = 1'b0;
	logic                 s_tready;
	logic [SAMPLE_W-1:0]  s_tdata   = '0;   // [15:0] sample_in
	logic [TUSER_W-1:0]   s_tuser   = '0;   // [2:0] chan, [3] seq_start
	logic                 m_tvalid;
	logic                 m_tready  = 1'b0;
	logic [SAMPLE_W-1:0]  m_tdata;          // [15:0] sample_out
	logic [TUSER_W-1:0]   m_tuser;          // [2:0] chan_out, [3] overflow
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [COEF_W-1:0]    cfg_data  = '0;

	// predictor copy of coefficients and per channel histories
	logic signed [15:0] coef_b [0:3];
	logic signed [15:0] coef_a [1:3];
	logic signed [15:0] hist_x [NUM_CH][HIST_SLOTS];
	logic signed [15:0] hist_y [NUM_CH][HIST_SLOTS];

	filter_out_t pending_out[$];
	filter_out_t mon_want;
	step_t       plan[$];

	int errors         = 0;
	int n_items        = 0;
	int n_results      = 0;
	int n_ovf          = 0;
	int n_writes       = 0;
	int stall_cycles   = 0;
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;

	iir_filter_direct_form #(
		.NUM_CHANNELS(NUM_CH)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// filter one sample of a channel and advance that channel's history
	function automatic filter_out_t run_filter(input logic [CHAN_W-1:0] ch, input logic start,
			input logic signed [15:0] x);
		longint      acc;
		longint      y;
		filter_out_t r;
		int          k;
		if (start) begin
			for (k = 0; k < HIST_SLOTS; k++) begin
				hist_x[ch][k] = '0;
				hist_y[ch][k] = '0;
			end
		end
		acc = longint'(coef_b[0]) * longint'(x);
		for (k = 1; k < TAPS; k++) begin
			acc += longint'(coef_b[k]) * longint'(hist_x[ch][k-1]);
			acc -= longint'(coef_a[k]) * longint'(hist_y[ch][k-1]);
		end
		// round half up, then floor shift
		y = (acc + ROUND_HALF) >>> FRAC_BITS;
		r.ovf = 1'b0;
		if (y > 32767) begin
			y = 32767;
			r.ovf = 1'b1;
		end else if (y < -32768) begin
			y = -32768;
			r.ovf = 1'b1;
		end
		for (k = HIST_SLOTS - 1; k > 0; k--) begin
			hist_x[ch][k] = hist_x[ch][k-1];
			hist_y[ch][k] = hist_y[ch][k-1];
		end
		hist_x[ch][0] = x;
		hist_y[ch][0] = y[15:0];
		r.chan = ch;
		r.value = y[15:0];
		return r;
	endfunction

	// table builders
	task automatic plan_write(input logic [2:0] idx, input logic [15:0] coef);
		step_t s;
		s = '0;
		s.is_write = 1'b1;
		s.idx = idx;
		s.coef = coef;
		plan.push_back(s);
	endtask

	task automatic plan_item(input logic [2:0] ch, input logic st, input logic [15:0] x);
		step_t s;
		s = '0;
		s.chan = ch;
		s.start = st;
		s.x = x;
		plan.push_back(s);
	endtask

	task automatic plan_known(input logic [2:0] ch, input logic st, input logic [15:0] x,
			input logic [15:0] want, input logic want_ovf);
		step_t s;
		s = '0;
		s.chan = ch;
		s.start = st;
		s.x = x;
		s.known = 1'b1;
		s.want = want;
		s.want_ovf = want_ovf;
		plan.push_back(s);
	endtask

	// stop sending and wait until every filtered item has come back
	task automatic settle();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending_out.size() != 0);
	endtask

	// register write on the configuration channel, mirrored into the predictor
	task automatic write_reg(input logic [2:0] idx, input logic [15:0] coef);
		cfg_index <= idx;
		cfg_data <= coef;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		n_writes++;
		case (idx)
			REG_B_TAP0: coef_b[0] = coef;
			REG_B_TAP1: coef_b[1] = coef;
			REG_B_TAP2: coef_b[2] = coef;
			REG_B_TAP3: coef_b[3] = coef;
			REG_A_FB1:  coef_a[1] = coef;
			REG_A_FB2:  coef_a[2] = coef;
			REG_A_FB3:  coef_a[3] = coef;
			default: ;  // unused index, ignored by the block
		endcase
		@(posedge clk);
	endtask

	// send one sample item, queue its expected output on acceptance
	task automatic send_item(input logic [2:0] ch, input logic st, input logic [15:0] x,
			input logic known, input logic [15:0] want, input logic want_ovf);
		filter_out_t r;
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tdata <= x;
		s_tuser <= {st, ch};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		r = run_filter(ch, st, x);
		if (known) begin
			r.value = want;
			r.ovf = want_ovf;
		end
		pending_out.push_back(r);
		n_items++;
	endtask

	// load a whole coefficient set of the given kind
	task automatic load_coefs(input int kind);
		logic [15:0] v [7];
		int          k;
		for (k = 0; k < 7; k++) begin
			case (kind)
				SET_UNITY:   v[k] = (k == 0) ? UNITY_Q14 : 16'd0;
				SET_EXTREME: v[k] = $urandom_range(1) ? POS_FULL : NEG_FULL;
				SET_MILD:    v[k] = (k < 4) ? 16'($urandom_range(16383)) - 16'd8192
					: 16'($urandom_range(8191)) - 16'd4096;
				SET_FIR:     v[k] = (k < 4) ? 16'($urandom) : 16'd0;
				default:     v[k] = 16'($urandom);
			endcase
		end
		write_reg(REG_B_TAP0, v[0]);
		write_reg(REG_B_TAP1, v[1]);
		write_reg(REG_B_TAP2, v[2]);
		write_reg(REG_B_TAP3, v[3]);
		write_reg(REG_A_FB1, v[4]);
		write_reg(REG_A_FB2, v[5]);
		write_reg(REG_A_FB3, v[6]);
		write_reg(CFG_IDX_UNUSED, 16'($urandom));
	endtask

	// receiver side back-pressure
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// output checker against the oldest expectation
	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			n_results++;
			if (m_tuser[3])
				n_ovf++;
			if (pending_out.size() == 0) begin
				errors++;
				$display("%0t: unexpected item chan %0d sample %0d ovf %0b", $time,
					m_tuser[2:0], $signed(m_tdata), m_tuser[3]);
			end else begin
				mon_want = pending_out.pop_front();
				if (m_tuser[2:0] !== mon_want.chan || m_tdata !== mon_want.value
						|| m_tuser[3] !== mon_want.ovf) begin
					errors++;
					$display("%0t: mismatch expected chan %0d sample %0d ovf %0b, got chan %0d sample %0d ovf %0b",
						$time, mon_want.chan, $signed(mon_want.value), mon_want.ovf,
						m_tuser[2:0], $signed(m_tdata), m_tuser[3]);
				end
			end
		end
	end

	// watchdog on cycles with no item moving anywhere
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("%0t: no progress for %0d cycles, %0d items outstanding", $time,
				stall_cycles, pending_out.size());
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		logic [2:0]  ch;
		logic        st;
		logic [15:0] x;
		int          i;
		int          phase;

		// predictor state after reset
		coef_b[0] = UNITY_Q14;
		for (i = 1; i < 4; i++) begin
			coef_b[i] = '0;
			coef_a[i] = '0;
		end
		for (i = 0; i < NUM_CH * HIST_SLOTS; i++) begin
			hist_x[i / HIST_SLOTS][i % HIST_SLOTS] = '0;
			hist_y[i / HIST_SLOTS][i % HIST_SLOTS] = '0;
		end

		// directed table: unity passthrough after reset
		plan_known(3'd0, 1'b1, 16'd0, 16'd0, 1'b0);
		plan_known(3'd7, 1'b0, POS_FULL, POS_FULL, 1'b0);
		plan_known(3'd3, 1'b0, NEG_FULL, NEG_FULL, 1'b0);
		plan_known(3'd5, 1'b0, 16'd1, 16'd1, 1'b0);
		// gain of -2.0 saturates both ways
		plan_write(REG_B_TAP0, NEG_FULL);
		plan_known(3'd1, 1'b0, NEG_FULL, POS_FULL, 1'b1);
		plan_known(3'd2, 1'b0, POS_FULL, NEG_FULL, 1'b1);
		plan_known(3'd4, 1'b0, 16'd0, 16'd0, 1'b0);
		// smallest gain shows the rounding of halves toward plus infinity
		plan_write(REG_B_TAP0, 16'd1);
		plan_known(3'd0, 1'b0, 16'd8192, 16'd1, 1'b0);
		plan_known(3'd0, 1'b0, -16'sd8192, 16'd0, 1'b0);
		plan_known(3'd0, 1'b0, -16'sd8193, 16'hffff, 1'b0);
		plan_known(3'd0, 1'b0, 16'd8191, 16'd0, 1'b0);
		// full positive feedforward, full negative feedback, unused index ignored
		plan_write(REG_B_TAP0, POS_FULL);
		plan_write(REG_B_TAP1, POS_FULL);
		plan_write(REG_B_TAP2, POS_FULL);
		plan_write(REG_B_TAP3, POS_FULL);
		plan_write(REG_A_FB1, NEG_FULL);
		plan_write(REG_A_FB2, NEG_FULL);
		plan_write(REG_A_FB3, NEG_FULL);
		plan_write(CFG_IDX_UNUSED, 16'h1234);
		plan_item(3'd6, 1'b1, POS_FULL);
		plan_item(3'd6, 1'b0, POS_FULL);
		plan_item(3'd6, 1'b0, NEG_FULL);
		plan_item(3'd6, 1'b1, NEG_FULL);
		plan_item(3'd6, 1'b0, 16'd100);
		// mixed signs with interleaved channels
		plan_write(REG_B_TAP0, 16'd8192);
		plan_write(REG_B_TAP1, 16'hc000);
		plan_write(REG_B_TAP2, 16'd4096);
		plan_write(REG_B_TAP3, NEG_FULL);
		plan_write(REG_A_FB1, POS_FULL);
		plan_write(REG_A_FB2, POS_FULL);
		plan_write(REG_A_FB3, POS_FULL);
		plan_item(3'd1, 1'b1, 16'd20000);
		plan_item(3'd2, 1'b1, -16'sd20000);
		plan_item(3'd1, 1'b0, 16'd300);
		plan_item(3'd2, 1'b0, 16'hffff);
		plan_item(3'd1, 1'b0, 16'h5555);
		plan_item(3'd1, 1'b0, 16'haaaa);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part, no idling
		foreach (plan[i]) begin
			if (plan[i].is_write) begin
				settle();
				write_reg(plan[i].idx, plan[i].coef);
			end else begin
				send_item(plan[i].chan, plan[i].start, plan[i].x, plan[i].known, plan[i].want,
					plan[i].want_ovf);
			end
		end

		// random phases, each loading its own coefficient set and taking one of four idling patterns
		for (phase = 0; phase < PHASES; phase++) begin
			settle();
			send_idle_pct = 0;
			recv_stall_pct = 0;
			load_coefs(phase % 5);
			case (phase % 4)
				1: send_idle_pct = 76;
				2: recv_stall_pct = 76;
				3: begin
					send_idle_pct = 20;
					recv_stall_pct = 20;
				end
				default: ;
			endcase
			for (i = 0; i < PHASE_ITEMS; i++) begin
				ch = 3'($urandom_range(NUM_CH - 1));
				st = ($urandom_range(99) < 4);
				case ($urandom_range(9))
					0: x = POS_FULL;
					1: x = NEG_FULL;
					2, 3: x = 16'($urandom_range(511)) - 16'd256;
					default: x = 16'($urandom);
				endcase
				send_item(ch, st, x, 1'b0, 16'd0, 1'b0);
				// now and then let the pipeline run dry mid-phase
				if ($urandom_range(199) == 0)
					settle();
			end
		end

		settle();
		recv_stall_pct = 0;
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("%0d items filtered across %0d coefficient sets, %0d register writes",
			n_items, PHASES + 5, n_writes);
		$display("%0d results checked, %0d of them saturated, under four idling patterns",
			n_results, n_ovf);
		if (errors == 0 && pending_out.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("%0d mismatches, %0d results never arrived", errors, pending_out.size());
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
